/* design/gbfp_pkg.sv */
// Shared types, constants and packing for the binary navigation frame parser.
package gbfp_pkg;

    // Framing bytes and message selectors
    localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND = 8'h62;
    localparam logic [7:0]  CLASS_NAV   = 8'h01;
    localparam logic [7:0]  ID_PVT      = 8'h07;
    localparam logic [7:0]  ID_VELNED   = 8'h12;
    localparam logic [15:0] LEN_PVT     = 16'd92;
    localparam logic [15:0] LEN_VELNED  = 16'd36;
    localparam logic [7:0]  FIX_3D      = 8'd3;

    // Default payload limit
    localparam int MAX_PAYLOAD_DEF = 128;

    // Payload word slots captured on the fly (byte offset / 4)
    localparam int WORD_20 = 5;
    localparam int WORD_24 = 6;
    localparam int WORD_28 = 7;
    localparam int WORD_36 = 9;
    localparam int WORD_60 = 15;
    localparam int WORD_64 = 16;

    // Update flag codes
    localparam logic [2:0] UPD_NONE   = 3'd0;
    localparam logic [2:0] UPD_SPEED  = 3'd4;
    localparam logic [2:0] UPD_ALL    = 3'd7;

    // Command queue depth
    localparam int CMD_FIFO_DEPTH = 2;

    // Result stream width: 174 field bits padded to 176
    localparam int M_TDATA_W = 176;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_PVT    = 2'd1,
        CMD_VELNED = 2'd2
    } cmd_kind_t;

    // One command from the framer to the sample unit
    typedef struct packed {
        cmd_kind_t   kind;
        logic        fix_ok;
        logic [7:0]  sat_count;
        logic [31:0] longitude;
        logic [31:0] latitude;
        logic [31:0] altitude;
        logic [31:0] speed;
        logic [31:0] heading;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    // Kept navigation sample
    typedef struct packed {
        logic        altitude_good;
        logic        speed_good;
        logic [31:0] heading_e5;
        logic [31:0] speed_mm_s;
        logic [31:0] altitude_mm;
        logic [31:0] latitude_e7;
        logic [31:0] longitude_e7;
        logic [7:0]  sat_count;
        logic        fix_good;
    } sample_t;

endpackage

/* design/gbfp_framer.sv */
// Byte framer: sync, header, Fletcher checksum, payload field capture, command build.
module gbfp_framer #(
    parameter int MAX_PAYLOAD = gbfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           byte_accept,
    input  logic [7:0]     rx_byte,
    output gbfp_pkg::cmd_t cmd
);

    localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);
    localparam int WIX_W = IDX_W - 2;

    typedef enum logic [8:0] {
        ST_SYNC1   = 9'b000000001,
        ST_SYNC2   = 9'b000000010,
        ST_CLASS   = 9'b000000100,
        ST_ID      = 9'b000001000,
        ST_LEN_LO  = 9'b000010000,
        ST_LEN_HI  = 9'b000100000,
        ST_PAYLOAD = 9'b001000000,
        ST_CK_A    = 9'b010000000,
        ST_CK_B    = 9'b100000000
    } frame_state_t;

    frame_state_t     state_reg, state_next;
    logic [7:0]       class_reg, class_next;
    logic [7:0]       id_reg, id_next;
    logic [15:0]      length_reg, length_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;

    // Captured payload words
    logic [31:0] w20_reg, w24_reg, w28_reg, w36_reg, w60_reg, w64_reg;

    logic [IDX_W-1:0] index_inc;
    logic [7:0]       fl_a;
    logic [7:0]       fl_b;
    logic [15:0]      len_full;
    logic             decode_pvt;
    logic             decode_vel;
    logic             good_ck_b;

    assign index_inc = index_reg + 1'b1;
    assign fl_a      = sum_a_reg + rx_byte;
    assign fl_b      = sum_b_reg + fl_a;
    assign len_full  = {rx_byte, length_reg[7:0]};

    // Next framer state
    always_comb begin
        state_next  = state_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        length_next = length_reg;
        index_next  = index_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        good_ck_b   = 1'b0;
        unique case (state_reg)
            ST_SYNC1: begin
                if (rx_byte == gbfp_pkg::SYNC_FIRST) begin
                    state_next = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                state_next = (rx_byte == gbfp_pkg::SYNC_SECOND) ? ST_CLASS : ST_SYNC1;
            end
            ST_CLASS: begin
                class_next = rx_byte;
                sum_a_next = rx_byte;
                sum_b_next = rx_byte;
                state_next = ST_ID;
            end
            ST_ID: begin
                id_next    = rx_byte;
                sum_a_next = fl_a;
                sum_b_next = fl_b;
                state_next = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                length_next = {8'd0, rx_byte};
                sum_a_next  = fl_a;
                sum_b_next  = fl_b;
                state_next  = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                length_next = len_full;
                sum_a_next  = fl_a;
                sum_b_next  = fl_b;
                index_next  = '0;
                if (len_full > 16'(MAX_PAYLOAD)) begin
                    state_next  = ST_SYNC1;
                    class_next  = '0;
                    id_next     = '0;
                    length_next = '0;
                    sum_a_next  = '0;
                    sum_b_next  = '0;
                end else if (len_full == 16'd0) begin
                    state_next = ST_CK_A;
                end else begin
                    state_next = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                index_next = index_inc;
                sum_a_next = fl_a;
                sum_b_next = fl_b;
                if (16'(index_inc) >= length_reg) begin
                    state_next = ST_CK_A;
                end
            end
            ST_CK_A: begin
                if (rx_byte == sum_a_reg) begin
                    state_next = ST_CK_B;
                end else begin
                    state_next  = ST_SYNC1;
                    class_next  = '0;
                    id_next     = '0;
                    length_next = '0;
                    index_next  = '0;
                    sum_a_next  = '0;
                    sum_b_next  = '0;
                end
            end
            ST_CK_B: begin
                good_ck_b   = (rx_byte == sum_b_reg);
                state_next  = ST_SYNC1;
                class_next  = '0;
                id_next     = '0;
                length_next = '0;
                index_next  = '0;
                sum_a_next  = '0;
                sum_b_next  = '0;
            end
            default: begin
                state_next  = ST_SYNC1;
                class_next  = '0;
                id_next     = '0;
                length_next = '0;
                index_next  = '0;
                sum_a_next  = '0;
                sum_b_next  = '0;
            end
        endcase
    end

    // Advance framer registers on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_SYNC1;
            class_reg  <= '0;
            id_reg     <= '0;
            length_reg <= '0;
            index_reg  <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
        end else if (byte_accept) begin
            state_reg  <= state_next;
            class_reg  <= class_next;
            id_reg     <= id_next;
            length_reg <= length_next;
            index_reg  <= index_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
        end
    end

    // Capture payload bytes that feed the decoded fields
    always_ff @(posedge aclk) begin
        if (byte_accept && state_reg == ST_PAYLOAD) begin
            if (index_reg[IDX_W-1:2] == WIX_W'(gbfp_pkg::WORD_20)) begin
                w20_reg[index_reg[1:0]*8 +: 8] <= rx_byte;
            end
            if (index_reg[IDX_W-1:2] == WIX_W'(gbfp_pkg::WORD_24)) begin
                w24_reg[index_reg[1:0]*8 +: 8] <= rx_byte;
            end
            if (index_reg[IDX_W-1:2] == WIX_W'(gbfp_pkg::WORD_28)) begin
                w28_reg[index_reg[1:0]*8 +: 8] <= rx_byte;
            end
            if (index_reg[IDX_W-1:2] == WIX_W'(gbfp_pkg::WORD_36)) begin
                w36_reg[index_reg[1:0]*8 +: 8] <= rx_byte;
            end
            if (index_reg[IDX_W-1:2] == WIX_W'(gbfp_pkg::WORD_60)) begin
                w60_reg[index_reg[1:0]*8 +: 8] <= rx_byte;
            end
            if (index_reg[IDX_W-1:2] == WIX_W'(gbfp_pkg::WORD_64)) begin
                w64_reg[index_reg[1:0]*8 +: 8] <= rx_byte;
            end
        end
    end

    // Classify a completed frame
    assign decode_pvt = good_ck_b && class_reg == gbfp_pkg::CLASS_NAV &&
                        id_reg == gbfp_pkg::ID_PVT && length_reg >= gbfp_pkg::LEN_PVT;
    assign decode_vel = good_ck_b && class_reg == gbfp_pkg::CLASS_NAV &&
                        id_reg == gbfp_pkg::ID_VELNED && length_reg >= gbfp_pkg::LEN_VELNED;

    // Build the command for this byte
    always_comb begin
        if (decode_pvt) begin
            cmd.kind = gbfp_pkg::CMD_PVT;
        end else if (decode_vel) begin
            cmd.kind = gbfp_pkg::CMD_VELNED;
        end else begin
            cmd.kind = gbfp_pkg::CMD_NONE;
        end
        cmd.fix_ok    = w20_reg[8] && (w20_reg[7:0] >= gbfp_pkg::FIX_3D);
        cmd.sat_count = w20_reg[31:24];
        cmd.longitude = w24_reg;
        cmd.latitude  = w28_reg;
        cmd.altitude  = w36_reg;
        cmd.speed     = decode_pvt ? w60_reg : w20_reg;
        cmd.heading   = decode_pvt ? w64_reg : w24_reg;
    end

endmodule

/* design/gbfp_cmd_fifo.sv */
// Short command queue between the framer and the sample unit.
module gbfp_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  gbfp_pkg::cmd_t push_data,
    output logic           not_full,
    input  logic           pop,
    output logic           not_empty,
    output gbfp_pkg::cmd_t pop_data
);

    localparam int DEPTH = gbfp_pkg::CMD_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gbfp_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Track pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/gbfp_sample_unit.sv */
// Sample unit: applies decode commands to the kept sample and drives the result register.
module gbfp_sample_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    input  gbfp_pkg::cmd_t                  cmd,
    output logic                            cmd_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gbfp_pkg::M_TDATA_W-1:0]  m_tdata
);

    gbfp_pkg::sample_t sample_reg;
    logic [2:0]        upd_reg;
    logic              valid_reg;
    logic [35:0]       speed_ext;
    logic [35:0]       speed_x10;
    logic [31:0]       speed_sat;

    // Scale cm/s to mm/s and saturate to 32 bits
    assign speed_ext = {{4{cmd.speed[31]}}, cmd.speed};
    assign speed_x10 = (speed_ext << 3) + (speed_ext << 1);

    always_comb begin
        if (speed_x10[35:31] == 5'b00000 || speed_x10[35:31] == 5'b11111) begin
            speed_sat = speed_x10[31:0];
        end else if (speed_x10[35]) begin
            speed_sat = 32'h8000_0000;
        end else begin
            speed_sat = 32'h7FFF_FFFF;
        end
    end

    assign cmd_pop = cmd_valid && (!valid_reg || m_tready);

    // Update sample and load the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            upd_reg    <= gbfp_pkg::UPD_NONE;
            sample_reg <= '0;
        end else begin
            if (cmd_pop) begin
                valid_reg <= 1'b1;
                unique case (cmd.kind)
                    gbfp_pkg::CMD_PVT: begin
                        upd_reg                  <= gbfp_pkg::UPD_ALL;
                        sample_reg.fix_good      <= cmd.fix_ok;
                        sample_reg.sat_count     <= cmd.sat_count;
                        sample_reg.longitude_e7  <= cmd.longitude;
                        sample_reg.latitude_e7   <= cmd.latitude;
                        sample_reg.altitude_mm   <= cmd.altitude;
                        sample_reg.speed_mm_s    <= cmd.speed;
                        sample_reg.heading_e5    <= cmd.heading;
                        sample_reg.speed_good    <= cmd.fix_ok;
                        sample_reg.altitude_good <= cmd.fix_ok;
                    end
                    gbfp_pkg::CMD_VELNED: begin
                        upd_reg               <= gbfp_pkg::UPD_SPEED;
                        sample_reg.speed_mm_s <= speed_sat;
                        sample_reg.heading_e5 <= cmd.heading;
                        sample_reg.speed_good <= 1'b1;
                    end
                    default: begin
                        upd_reg <= gbfp_pkg::UPD_NONE;
                    end
                endcase
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, sample_reg, upd_reg};

endmodule

/* design/gnss_binary_frame_parser.sv */
// Top level of the binary navigation frame parser.
//
// Input channel (s_): one receiver byte per transfer in s_tdata[7:0].
// Result channel (m_): exactly one result per input byte, in order, carrying
// the update flags of that byte and the kept navigation sample.
// Every byte passes through the framer, which tracks sync, header, payload and
// the Fletcher checksum and captures the payload words that the decoders use;
// a command per byte goes into a two-entry queue, and the sample unit applies
// it and loads the result register.
// The queue takes the command for a byte at its transfer, and the sample
// unit loads the result register from the queue once that register is free
// (empty, or its result taken with m_tready high).
// Throughput: while m_tready is high, one byte per cycle; the framer does
// fixed work per byte and the sample unit takes one command per cycle.
// Reset (aresetn low, synchronous): framer returns to waiting for the first
// sync byte, the queue empties, the kept sample clears to zero, m_tvalid drops.
// Receiver stall: the result register holds, the queue fills, and s_tready
// falls once both queue entries are taken.
module gnss_binary_frame_parser #(
    parameter int MAX_PAYLOAD = gbfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] updates, [3] fix flag, [11:4] sat_count, [43:12] longitude_e7,
    // [75:44] latitude_e7, [107:76] altitude_mm, [139:108] speed_mm_s,
    // [171:140] heading_e5, [172] speed flag, [173] altitude flag, [175:174] zero
    output logic [gbfp_pkg::M_TDATA_W-1:0] m_tdata
);

    logic           byte_accept;
    gbfp_pkg::cmd_t front_cmd;
    gbfp_pkg::cmd_t back_cmd;
    logic           fifo_not_empty;
    logic           fifo_pop;

    assign byte_accept = s_tvalid && s_tready;

    // Front: framing and classification
    gbfp_framer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .cmd         (front_cmd)
    );

    // Queue between front and back
    gbfp_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (byte_accept),
        .push_data (front_cmd),
        .not_full  (s_tready),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .pop_data  (back_cmd)
    );

    // Back: sample update and result register
    gbfp_sample_unit u_sample_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (fifo_not_empty),
        .cmd       (back_cmd),
        .cmd_pop   (fifo_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* design/gbfp_checker.sv */
// Port-level checker for the frame parser and its bind to the top level.
module gbfp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gbfp_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [2:0] upd;

    assign upd = m_tdata[2:0];

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Only the three update codes appear
    a_upd_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (upd == gbfp_pkg::UPD_NONE || upd == gbfp_pkg::UPD_SPEED ||
                      upd == gbfp_pkg::UPD_ALL))
        else $error("illegal update flags");

    // Velocity update always marks speed as valid
    a_vel_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && upd == gbfp_pkg::UPD_SPEED |-> m_tdata[172])
        else $error("velocity update without speed valid");

    // Position update copies the fix flag into both validity bits
    a_pvt_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && upd == gbfp_pkg::UPD_ALL |->
            m_tdata[172] == m_tdata[3] && m_tdata[173] == m_tdata[3])
        else $error("position update validity mismatch");

    // After a reset edge no result is pending and the input is open
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input blocked right after reset");

endmodule

bind gnss_binary_frame_parser gbfp_checker u_gbfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
